// ----- rtl/lcg48br_pkg.sv -----
// Package for the 48-bit LCG with bounded pick.
// Constants of the generator and the status type shared by the serial units.
// No dependencies.
package lcg48br_pkg;

  localparam int StateW = 48;
  localparam int SeedW  = 32;
  localparam int ValW   = 31;
  localparam int MulW   = 35;
  localparam int LowW   = 16;

  localparam logic [MulW-1:0]   LCG_MULT     = 35'h5DEECE66D;
  localparam logic [StateW-1:0] LCG_INC      = 48'h00000000000B;
  localparam logic [LowW-1:0]   LCG_LOW_INIT = 16'h330E;
  localparam logic [ValW-1:0]   RAW_MAX      = 31'h7FFFFFFF;

  // Status of a multi-cycle serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- rtl/lcg48br_mul.sv -----
// Bit-serial multiply-add: state * LCG_MULT + LCG_INC mod 2^48.
// One multiplier bit per cycle, one 48-bit add per step. Uses lcg48br_pkg.
module lcg48br_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [lcg48br_pkg::StateW-1:0]    state_in,
  output lcg48br_pkg::unit_stat_t           stat,
  output logic [lcg48br_pkg::StateW-1:0]    product
);
  import lcg48br_pkg::*;

  localparam int CntW = $clog2(MulW);

  logic [StateW-1:0] acc_r, acc_nxt;
  logic [StateW-1:0] mcand_r;
  logic [MulW-1:0]   mplier_r;
  logic [CntW-1:0]   cnt_r;
  logic              busy_r, done_r;

  // Conditional add of the shifted multiplicand
  always_comb begin
    acc_nxt = acc_r;
    if (mplier_r[0]) begin
      acc_nxt = acc_r + mcand_r;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == CntW'(MulW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= LCG_INC;
      mcand_r  <= state_in;
      mplier_r <= LCG_MULT;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mcand_r  <= {mcand_r[StateW-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[MulW-1:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

// ----- rtl/lcg48br_div.sv -----
// Restoring bit-serial divider for 31-bit unsigned operands.
// One quotient bit per cycle. Uses lcg48br_pkg.
module lcg48br_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lcg48br_pkg::ValW-1:0]    dividend,
  input  logic [lcg48br_pkg::ValW-1:0]    divisor,
  output lcg48br_pkg::unit_stat_t         stat,
  output logic [lcg48br_pkg::ValW-1:0]    quotient
);
  import lcg48br_pkg::*;

  localparam int CntW = $clog2(ValW);

  logic [ValW-1:0] rem_r, rem_nxt;
  logic [ValW-1:0] quo_r;
  logic [ValW-1:0] dvs_r;
  logic [ValW:0]   rem_sh;
  logic            ge;
  logic [CntW-1:0] cnt_r;
  logic            busy_r, done_r;

  // Shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[ValW-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? ValW'(rem_sh - {1'b0, dvs_r}) : rem_sh[ValW-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == CntW'(ValW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend register shifts out while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[ValW-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ----- rtl/lcg48_bounded_random_top.sv -----
// 48-bit LCG bounded random generator, top level.
// Instantiates lcg48br_mul and lcg48br_div; uses lcg48br_pkg.
//
// Each accepted item advances the 48-bit state once and returns bits 47..17
// as out_raw_value, plus out_bounded_index = raw / ((2^31-1)/bound), clamped
// to bound-1 (0 for a bound of zero). One item is in work at a time. An item
// passes through the bit-serial multiplier (one constant bit per cycle),
// then two passes through the shared restoring divider, and is then loaded
// into the output register; with a bound of zero the divides are skipped.
// A stalled result holds the sequencer until the output register takes it.
// The result sits in an output register, so the next item is taken while it
// waits. Writing cfg_seed loads the state with {seed, 16'h330E}; a seed
// write is taken only when idle with no result waiting, and a pending seed
// write holds off the next item.
module lcg48_bounded_random_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcg48br_pkg::SeedW-1:0] cfg_seed,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lcg48br_pkg::ValW-1:0]  in_bound,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcg48br_pkg::ValW-1:0]  out_raw_value,
  output logic [lcg48br_pkg::ValW-1:0]  out_bounded_index
);
  import lcg48br_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV1 = 5'b00100,
    ST_DIV2 = 5'b01000,
    ST_DONE = 5'b10000
  } fsm_t;

  fsm_t              st_r, st_nxt;
  logic [StateW-1:0] lcg_state_r;
  logic [ValW-1:0]   bound_r;
  logic [ValW-1:0]   idx_r;
  logic              out_valid_r;
  logic [ValW-1:0]   out_raw_r, out_idx_r;

  logic              in_acc, cfg_acc, out_load;
  logic              mul_start, div_start;
  logic [StateW-1:0] product;
  logic [ValW-1:0]   div_dvd, div_dvs, quotient;
  logic [ValW-1:0]   raw;
  unit_stat_t        mul_stat, div_stat;

  // Seed writes go first and only with nothing in flight
  assign in_ready  = (st_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (st_r == ST_IDLE) && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_load  = (st_r == ST_DONE) && (!out_valid_r || out_ready);
  assign raw       = lcg_state_r[StateW-1:StateW-ValW];

  // Unit starts and divider operand select
  assign mul_start = in_acc;
  assign div_start = ((st_r == ST_MUL) && mul_stat.done && (bound_r != '0)) ||
                     ((st_r == ST_DIV1) && div_stat.done);
  assign div_dvd   = (st_r == ST_MUL) ? RAW_MAX : raw;
  assign div_dvs   = (st_r == ST_MUL) ? bound_r : quotient;

  lcg48br_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_start),
    .state_in (lcg_state_r),
    .stat     (mul_stat),
    .product  (product)
  );

  lcg48br_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_stat.done) begin
          st_nxt = (bound_r == '0) ? ST_DONE : ST_DIV1;
        end
      end
      ST_DIV1: if (div_stat.done) st_nxt = ST_DIV2;
      ST_DIV2: if (div_stat.done) st_nxt = ST_DONE;
      ST_DONE: if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Generator state: reset and seed load, update after the multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_state_r <= {SeedW'(0), LCG_LOW_INIT};
    end else if (cfg_acc) begin
      lcg_state_r <= {cfg_seed, LCG_LOW_INIT};
    end else if ((st_r == ST_MUL) && mul_stat.done) begin
      lcg_state_r <= product;
    end
  end

  // Item bound and bounded index with clamp
  always_ff @(posedge clk) begin
    if (in_acc) begin
      bound_r <= in_bound;
    end
    if ((st_r == ST_MUL) && mul_stat.done) begin
      idx_r <= '0;
    end else if ((st_r == ST_DIV2) && div_stat.done) begin
      idx_r <= (quotient >= bound_r) ? (bound_r - ValW'(1)) : quotient;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_raw_r <= raw;
      out_idx_r <= idx_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_raw_value     = out_raw_r;
  assign out_bounded_index = out_idx_r;

  // Checks
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  a_mul_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> mul_stat.busy)
    else $error("multiplier did not start on item");

  a_seed_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (lcg_state_r[LowW-1:0] == LCG_LOW_INIT))
    else $error("seed load lost low constant");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (bound_r != '0)) |-> (idx_r < bound_r))
    else $error("bounded index not below bound");

endmodule
